>>> rtl/core/double_ended_queue_core_assert.svh
// Assertion macros for the double-ended queue core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DEQ_ASSERT(lbl, expr, msg)
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue core.
// No dependencies.
package deq_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int COUNT_W        = 11;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_PEEK_FRONT = 3'd4,
		MODE_PEEK_BACK  = 3'd5,
		MODE_SIZE       = 3'd6,
		MODE_CLEAR      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] read_value;
		logic [COUNT_W-1:0] count;
	} rsp_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	typedef struct packed {
		status_t status;
		logic    take;
	} res_t;

endpackage

>>> rtl/core/deq_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> rtl/core/deq_ctrl.sv
// Front/back index and count control; issues at most one RAM access per request.
// Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  req_t                  req,
	output mem_ctl_t              mem_ctl,
	output logic [AW-1:0]         mem_addr,
	output logic [DATA_WIDTH-1:0] mem_wdata,
	output res_t                  res,
	output logic [CW-1:0]         count_next
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [AW-1:0] front_q, back_q, front_d, back_d;
	logic [AW-1:0] front_prev, front_next, back_prev, back_next;
	logic [CW-1:0] count_q;
	logic          full, empty;
	logic [63:0]   val_ext;

	assign full       = (count_q == FULL);
	assign empty      = (count_q == '0);
	assign front_prev = (front_q == '0) ? LAST : front_q - 1'b1;
	assign front_next = (front_q == LAST) ? '0 : front_q + 1'b1;
	assign back_prev  = (back_q == '0) ? LAST : back_q - 1'b1;
	assign back_next  = (back_q == LAST) ? '0 : back_q + 1'b1;
	assign val_ext    = {32'b0, req.push_value};
	assign mem_wdata  = val_ext[DATA_WIDTH-1:0];

	always_comb begin
		mem_ctl    = '0;
		mem_addr   = front_q;
		res.status = ST_OK;
		res.take   = 1'b0;
		front_d    = front_q;
		back_d     = back_q;
		count_next = count_q;
		case (req.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					mem_ctl.we = 1'b1;
					count_next = count_q + 1'b1;
					if (req.mode == MODE_PUSH_FRONT) begin
						mem_addr = front_prev;
						front_d  = front_prev;
					end else begin
						mem_addr = back_q;
						back_d   = back_next;
					end
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					mem_ctl.re = 1'b1;
					res.take   = 1'b1;
					case (req.mode)
						MODE_POP_FRONT: begin
							mem_addr   = front_q;
							front_d    = front_next;
							count_next = count_q - 1'b1;
						end
						MODE_POP_BACK: begin
							mem_addr   = back_prev;
							back_d     = back_prev;
							count_next = count_q - 1'b1;
						end
						MODE_PEEK_FRONT: mem_addr = front_q;
						default:         mem_addr = back_prev;
					endcase
				end
			end
			MODE_SIZE: ;
			default: begin
				front_d    = '0;
				back_d     = '0;
				count_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_next;
		end
	end

endmodule

>>> rtl/core/double_ended_queue_core.sv
// Top level of the double-ended queue core: request stage, RAM, response register.
// Depends on deq_pkg, deq_ram, deq_ctrl and double_ended_queue_core_assert.svh.
//
//  channel | payload | handshake          | direction
//  req     | req_t   | req_valid/stall    | in
//  rsp     | rsp_t   | rsp_valid/stall    | out
//
// One request per cycle while req_stall is low; valid_s1 then feeds rsp_valid.
// The RAM access is issued at acceptance; the registered read returns in the next cycle.
// Reset clears indices and count; stored words need no clearing.
// A stalled response holds the request stage; req_stall rises only then.
`include "double_ended_queue_core_assert.svh"
module double_ended_queue_core import deq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	mem_ctl_t              mem_ctl;
	logic [AW-1:0]         mem_addr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
	res_t                  res;
	logic [CW-1:0]         count_next;
	logic                  accept, adv;

	logic                  valid_s1;
	res_t                  res_s1;
	logic [CW-1:0]         count_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [63:0]           rd_ext;
	logic [CW+COUNT_W-1:0] cnt_ext;
	logic                  full_s1, empty_s1;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	deq_ctrl #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req        (req),
		.mem_ctl    (mem_ctl),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.res        (res),
		.count_next (count_next)
	);

	deq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (accept && mem_ctl.we),
		.re    (accept && mem_ctl.re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign rd_ext  = 64'(signed'(mem_rdata));
	assign cnt_ext = (CW + COUNT_W)'(count_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1   <= res;
			count_s1 <= count_next;
		end
		if (adv && valid_s1) begin
			rsp_q.status     <= res_s1.status;
			rsp_q.read_value <= res_s1.take ? rd_ext[31:0] : '0;
			rsp_q.count      <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full_s1  = valid_s1 && (res_s1.status == ST_FULL);
	assign empty_s1 = valid_s1 && (res_s1.status == ST_EMPTY);

	`DEQ_ASSERT_NEXT(a_accept_fills, accept, valid_s1, "accepted word missing from stage")
	`DEQ_ASSERT_NEXT(a_hold_stalled, valid_s1 && !adv, valid_s1, "stalled stage word lost")
	`DEQ_ASSERT(a_full_count, !full_s1 || count_s1 == FULL_CNT, "full status with count below depth")
	`DEQ_ASSERT(a_empty_count, !empty_s1 || count_s1 == '0, "empty status with nonzero count")

endmodule

>>> tb/tb_double_ended_queue_core.sv
// Self-checking testbench for double_ended_queue_core: bursty request driver, stalling
// response monitor and an in-order predictor of the ring-buffer deque.
// Depends on deq_pkg and the double_ended_queue_core RTL.
`timescale 1ns / 100ps
module tb_double_ended_queue_core;
	import deq_pkg::*;

	localparam int DW         = DATA_WIDTH_DEF;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		req_t word;
		bit   wait_idle;
	} pend_t;

	logic clk;
	logic arst_n;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pend_t pending[$];
	rsp_t  expected[$];

	// deque shadow
	logic [DW-1:0] slots [DEPTH_DEF];
	int head = 0;
	int tail = 0;
	int held = 0;

	bit req_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	bit stalling = 1'b0;
	int run_left = 0;
	int idle_cycles = 0;
	int errors = 0;

	double_ended_queue_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int slot_fwd(int i);
		return (i + 1 >= DEPTH_DEF) ? 0 : i + 1;
	endfunction

	function automatic int slot_back(int i);
		return (i == 0) ? DEPTH_DEF - 1 : i - 1;
	endfunction

	function automatic logic signed [31:0] widen(logic [DW-1:0] w);
		logic signed [DW-1:0] s;
		s = w;
		return 32'(s);
	endfunction

	function automatic rsp_t deq_apply(req_t r);
		rsp_t o;
		o.status = ST_OK;
		o.read_value = '0;
		case (r.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (held >= DEPTH_DEF) begin
					o.status = ST_FULL;
				end else if (r.mode == MODE_PUSH_FRONT) begin
					head = slot_back(head);
					slots[head] = r.push_value[DW-1:0];
					held++;
				end else begin
					slots[tail] = r.push_value[DW-1:0];
					tail = slot_fwd(tail);
					held++;
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					case (r.mode)
						MODE_POP_FRONT: begin
							o.read_value = widen(slots[head]);
							head = slot_fwd(head);
							held--;
						end
						MODE_POP_BACK: begin
							tail = slot_back(tail);
							o.read_value = widen(slots[tail]);
							held--;
						end
						MODE_PEEK_FRONT: begin
							o.read_value = widen(slots[head]);
						end
						default: begin
							o.read_value = widen(slots[slot_back(tail)]);
						end
					endcase
				end
			end
			MODE_CLEAR: begin
				held = 0;
				head = 0;
				tail = 0;
			end
			default: ;
		endcase
		o.count = held[COUNT_W-1:0];
		return o;
	endfunction

	function automatic mode_t rand_op(int push_pct, int pop_pct);
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return mode_t'(MODE_PUSH_FRONT + $urandom_range(0, 1));
		if (r < push_pct + pop_pct)
			return mode_t'(MODE_POP_FRONT + $urandom_range(0, 1));
		k = $urandom_range(0, 9);
		if (k == 0)
			return MODE_CLEAR;
		if (k < 3)
			return MODE_SIZE;
		return mode_t'(MODE_PEEK_FRONT + $urandom_range(0, 1));
	endfunction

	task automatic add(mode_t m, logic [31:0] v, bit hold = 1'b0);
		pend_t p;
		p.word.mode = m;
		p.word.push_value = v;
		p.wait_idle = hold;
		pending.insert(pending.size(), p);
	endtask

	task automatic add_mix(int n, int push_pct, int pop_pct);
		for (int i = 0; i < n; i++)
			add(rand_op(push_pct, pop_pct), $urandom());
	endtask

	// driver: words change on the falling edge, held while stalled
	always @(negedge clk) begin : drv
		logic nxt_valid;
		nxt_valid = req_valid;
		if (arst_n) begin
			if (req_taken) begin
				pending.delete(0);
				nxt_valid = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
				end
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0 &&
						!(pending[0].wait_idle && expected.size() != 0)) begin
					nxt_valid = 1'b1;
					req <= pending[0].word;
				end
			end
		end
		req_valid <= nxt_valid;
	end

	// receiver stall pattern
	always @(negedge clk) begin : rcv
		if (run_left > 0) begin
			run_left--;
		end else begin
			stalling = !stalling;
			if (stalling)
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
					: $urandom_range(1, 4);
			else
				run_left = $urandom_range(0, 30);
		end
		rsp_stall <= stalling;
	end

	// prediction, response check, watchdog
	always @(posedge clk) begin : mon
		rsp_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall)
				expected.insert(expected.size(), deq_apply(req));
			if (rsp_valid && !rsp_stall) begin
				if (expected.size() == 0) begin
					$error("response word with nothing expected");
					errors++;
				end else begin
					want = expected[0];
					expected.delete(0);
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, rsp.read_value);
						errors++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						errors++;
					end
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[double_ended_queue_core] ERROR");
				$finish;
			end
		end
	end

	initial begin : stim
		int pushes;
		arst_n = 1'b0;

		// empty queue, extremes, ring wrap at slot zero, clear
		add(MODE_POP_FRONT, $urandom());
		add(MODE_POP_BACK, $urandom());
		add(MODE_PEEK_FRONT, $urandom());
		add(MODE_PEEK_BACK, $urandom());
		add(MODE_SIZE, $urandom());
		add(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
		add(MODE_PUSH_FRONT, 32'h8000_0000);
		add(MODE_PUSH_BACK, 32'hFFFF_FFFF);
		add(MODE_PUSH_BACK, 32'h0000_0000);
		add(MODE_PEEK_FRONT, 32'hFFFF_FFFF);
		add(MODE_PEEK_BACK, 32'h0000_0000);
		add(MODE_SIZE, 32'h8000_0000);
		add(MODE_POP_BACK, $urandom());
		add(MODE_POP_FRONT, $urandom());
		add(MODE_POP_BACK, $urandom());
		add(MODE_POP_FRONT, $urandom());
		add(MODE_POP_FRONT, $urandom());
		add(MODE_PUSH_BACK, 32'h5555_5555);
		add(MODE_PEEK_BACK, $urandom());
		add(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
		add(MODE_POP_FRONT, $urandom());
		add(MODE_CLEAR, $urandom());
		add(MODE_PEEK_BACK, $urandom());
		add(MODE_POP_FRONT, $urandom());

		add_mix(150, 40, 35);

		// fill to capacity and beyond, after the pipe has drained
		add(MODE_CLEAR, $urandom(), 1'b1);
		pushes = 0;
		while (pushes < DEPTH_DEF + 6) begin
			if ($urandom_range(0, 15) == 0) begin
				add(mode_t'(MODE_PEEK_FRONT + $urandom_range(0, 2)), $urandom());
			end else begin
				add(mode_t'(MODE_PUSH_FRONT + $urandom_range(0, 1)), $urandom());
				pushes++;
			end
		end
		add(MODE_PEEK_FRONT, $urandom());
		add(MODE_PEEK_BACK, $urandom());
		add(MODE_POP_BACK, $urandom());
		add(MODE_PUSH_FRONT, $urandom());
		add(MODE_PUSH_BACK, $urandom());

		add_mix(100, 20, 65);
		add(MODE_SIZE, $urandom(), 1'b1);
		add_mix(110, 45, 40);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || expected.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && expected.size() == 0)
			$display("[double_ended_queue_core] OK");
		else
			$display("[double_ended_queue_core] ERROR");
		$finish;
	end

endmodule
